// ===== rtl/spq_pkg.sv =====
// Shared types and constants for the stable priority queue.
// No dependencies; every other file in the project depends on this package.
package spq_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 16;
    localparam int unsigned PRIO_W          = 8;
    localparam int unsigned ID_W            = 16;
    localparam int unsigned COUNT_W         = 5;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_command;

    typedef struct packed {
        logic exec;
    } t_dp_cmd;

    typedef struct packed {
        logic               removed_valid;
        logic [ID_W-1:0]    removed_id;
        logic [PRIO_W-1:0]  removed_priority;
        logic [COUNT_W-1:0] entry_count;
        logic               queue_empty;
        logic               insert_dropped;
    } t_result;

endpackage

// ===== rtl/spq_cmd_if.sv =====
// Handshake channel that carries insert and remove commands into the queue.
// Depends on spq_pkg for field widths.
interface spq_cmd_if;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [spq_pkg::PRIO_W-1:0]   entry_priority;
    logic [spq_pkg::ID_W-1:0]     entry_id;

    modport source (output valid, command, entry_priority, entry_id, input ready);
    modport sink   (input valid, command, entry_priority, entry_id, output ready);
endinterface

// ===== rtl/spq_res_if.sv =====
// Handshake channel that carries one result per command out of the queue.
// Depends on spq_pkg for field widths.
interface spq_res_if;
    logic                          valid;
    logic                          ready;
    logic                          removed_valid;
    logic [spq_pkg::ID_W-1:0]      removed_id;
    logic [spq_pkg::PRIO_W-1:0]    removed_priority;
    logic [spq_pkg::COUNT_W-1:0]   entry_count;
    logic                          queue_empty;
    logic                          insert_dropped;

    modport source (output valid, removed_valid, removed_id, removed_priority,
                    entry_count, queue_empty, insert_dropped, input ready);
    modport sink   (input valid, removed_valid, removed_id, removed_priority,
                    entry_count, queue_empty, insert_dropped, output ready);
endinterface

// ===== rtl/spq_ctrl.sv =====
// Handshake controller: accepts a command, issues it to the datapath and
// holds the result until it is taken. Depends on spq_pkg.
module spq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output spq_pkg::t_dp_cmd  o_cmd
);
    import spq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_HOLD = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_in_ready = (r_state == ST_IDLE) || i_out_ready;
        o_cmd.exec = i_in_valid && o_in_ready;
        case (r_state)
            ST_IDLE: begin
                n_state = o_cmd.exec ? ST_HOLD : ST_IDLE;
            end
            ST_HOLD: begin
                if (o_cmd.exec) begin
                    n_state = ST_HOLD;
                end else if (i_out_ready) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_HOLD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = (r_state == ST_HOLD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ===== rtl/spq_datapath.sv =====
// Datapath: a row of compare-and-shift slots, the occupancy counter and the
// result register. Depends on spq_pkg.
module spq_datapath #(
    parameter int unsigned Depth = spq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  spq_pkg::t_dp_cmd            i_cmd,
    input  logic                        i_command,
    input  logic [spq_pkg::PRIO_W-1:0]  i_prio,
    input  logic [spq_pkg::ID_W-1:0]    i_id,
    output spq_pkg::t_result            o_result
);
    import spq_pkg::*;

    localparam int unsigned OccW = $clog2(Depth + 1);

    logic [PRIO_W-1:0] r_slot_prio [Depth];
    logic [ID_W-1:0]   r_slot_id   [Depth];
    logic [PRIO_W-1:0] n_slot_prio [Depth];
    logic [ID_W-1:0]   n_slot_id   [Depth];
    logic [OccW-1:0]   r_occ;
    logic [OccW-1:0]   n_occ;
    t_result           r_res;
    t_result           n_res;
    logic [Depth-1:0]  w_ge;
    logic              w_full;
    logic              w_empty;
    logic              w_is_remove;
    logic              w_do_insert;
    logic              w_do_remove;

    assign w_full      = (r_occ == OccW'(Depth));
    assign w_empty     = (r_occ == '0);
    assign w_is_remove = (i_command == CMD_REMOVE);
    assign w_do_insert = i_cmd.exec && !w_is_remove && !w_full;
    assign w_do_remove = i_cmd.exec && w_is_remove && !w_empty;

    for (genvar k = 0; k < Depth; k++) begin : g_slot
        assign w_ge[k] = (OccW'(k) < r_occ) && (r_slot_prio[k] >= i_prio);

        always_comb begin
            n_slot_prio[k] = r_slot_prio[k];
            n_slot_id[k]   = r_slot_id[k];
            if (w_do_insert && !w_ge[k]) begin
                if (k == 0) begin
                    n_slot_prio[k] = i_prio;
                    n_slot_id[k]   = i_id;
                end else if (w_ge[(k == 0) ? 0 : k - 1]) begin
                    n_slot_prio[k] = i_prio;
                    n_slot_id[k]   = i_id;
                end else begin
                    n_slot_prio[k] = r_slot_prio[(k == 0) ? 0 : k - 1];
                    n_slot_id[k]   = r_slot_id[(k == 0) ? 0 : k - 1];
                end
            end else if (w_do_remove && (k + 1 < Depth)) begin
                n_slot_prio[k] = r_slot_prio[(k + 1 < Depth) ? k + 1 : k];
                n_slot_id[k]   = r_slot_id[(k + 1 < Depth) ? k + 1 : k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_slot_prio[k] <= n_slot_prio[k];
            r_slot_id[k]   <= n_slot_id[k];
        end
    end

    always_comb begin
        n_occ = r_occ;
        if (w_do_insert) begin
            n_occ = r_occ + OccW'(1);
        end else if (w_do_remove) begin
            n_occ = r_occ - OccW'(1);
        end
        n_res                  = r_res;
        if (i_cmd.exec) begin
            n_res.removed_valid    = w_do_remove;
            n_res.removed_id       = w_do_remove ? r_slot_id[0] : '0;
            n_res.removed_priority = w_do_remove ? r_slot_prio[0] : '0;
            n_res.entry_count      = COUNT_W'(n_occ);
            n_res.queue_empty      = (n_occ == '0);
            n_res.insert_dropped   = !w_is_remove && w_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_result = r_res;
endmodule

// ===== rtl/stable_priority_queue_unit.sv =====
// Stable bounded priority queue: controller plus compare-and-shift datapath.
// Latency: a result is valid the cycle after its command transfer.
// Throughput: one command per cycle while the output is ready; every slot is updated
// in parallel and the result register is reloaded in the same cycle that it is taken.
// Reset: synchronous, active low; clears the occupancy and drops any result waiting
// to be taken. Slot contents and result fields are not reset, since only occupied
// slots and valid results are ever read.
module stable_priority_queue_unit #(
    parameter int unsigned QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    spq_cmd_if.sink       i_cmd,
    spq_res_if.source     o_res
);
    import spq_pkg::*;

    t_dp_cmd w_cmd;
    t_result w_result;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .i_out_ready (o_res.ready),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_res.valid),
        .o_cmd       (w_cmd)
    );

    spq_datapath #(
        .Depth (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_command (i_cmd.command),
        .i_prio    (i_cmd.entry_priority),
        .i_id      (i_cmd.entry_id),
        .o_result  (w_result)
    );

    assign o_res.removed_valid    = w_result.removed_valid;
    assign o_res.removed_id       = w_result.removed_id;
    assign o_res.removed_priority = w_result.removed_priority;
    assign o_res.entry_count      = w_result.entry_count;
    assign o_res.queue_empty      = w_result.queue_empty;
    assign o_res.insert_dropped   = w_result.insert_dropped;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> o_res.valid)
        else $error("No result after a command transfer.");

    a_remove_not_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.removed_valid) |-> !o_res.insert_dropped)
        else $error("A remove result flags a dropped insert.");

    a_empty_remove_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.removed_valid) |->
        (o_res.removed_id == '0 && o_res.removed_priority == '0))
        else $error("Result without a removed entry carries nonzero fields.");
endmodule
